/* design/record_scheduler_flash_slots_core_assert.svh */
// ----------------------------------------------------------------------------
// Record scheduler assertion macros
// Shared concurrent assertion forms for the record scheduler checkers.
// ----------------------------------------------------------------------------
`ifndef RECORD_SCHEDULER_FLASH_SLOTS_CORE_ASSERT_SVH
`define RECORD_SCHEDULER_FLASH_SLOTS_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSFS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("record scheduler assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RSFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("record scheduler assertion failed");

`endif

/* design/rsfs_pkg.sv */
// ----------------------------------------------------------------------------
// Record scheduler package
// Shared types, register indexes, opcodes and sizes of the record scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rsfs_pkg;

  localparam int SLOT_COUNT = 10;
  localparam int SLOT_W     = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_HOUR_LIMIT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAY_LIMIT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BATTERY_MIN_MV = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEADY_TICKS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ERASE_LIMIT    = 3'd4;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_FUEL  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [16:0] HOUR_LIMIT_RST     = 17'd3600;
  localparam logic [16:0] DAY_LIMIT_RST      = 17'd86400;
  localparam logic [12:0] BATTERY_MIN_MV_RST = 13'd2500;
  localparam logic [7:0]  STEADY_TICKS_RST   = 8'd15;
  localparam logic [15:0] ERASE_LIMIT_RST    = 16'd1000;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] elapsed_seconds;
    logic [12:0] battery_mv;
  } in_item_t;

  typedef struct packed {
    logic              record_written;
    logic              page_erased;
    logic [SLOT_W-1:0] slot_number;
    logic [15:0]       wear_count;
    logic              worn_out;
  } out_item_t;

  typedef struct packed {
    logic [16:0] hour_limit;
    logic [16:0] day_limit;
    logic [12:0] battery_min_mv;
    logic [7:0]  steady_ticks;
    logic [15:0] erase_limit;
  } cfg_regs_t;

endpackage

/* design/rsfs_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Record scheduler configuration registers
// Holds the limits and thresholds written over the configuration channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsfs_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [rsfs_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [rsfs_pkg::CFG_DATA_W-1:0]   wr_data,
  output rsfs_pkg::cfg_regs_t               cfg
);

  rsfs_pkg::cfg_regs_t cfg_r;
  rsfs_pkg::cfg_regs_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        rsfs_pkg::REG_HOUR_LIMIT:     cfg_nxt.hour_limit     = wr_data[16:0];
        rsfs_pkg::REG_DAY_LIMIT:      cfg_nxt.day_limit      = wr_data[16:0];
        rsfs_pkg::REG_BATTERY_MIN_MV: cfg_nxt.battery_min_mv = wr_data[12:0];
        rsfs_pkg::REG_STEADY_TICKS:   cfg_nxt.steady_ticks   = wr_data[7:0];
        rsfs_pkg::REG_ERASE_LIMIT:    cfg_nxt.erase_limit    = wr_data[15:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hour_limit     <= rsfs_pkg::HOUR_LIMIT_RST;
      cfg_r.day_limit      <= rsfs_pkg::DAY_LIMIT_RST;
      cfg_r.battery_min_mv <= rsfs_pkg::BATTERY_MIN_MV_RST;
      cfg_r.steady_ticks   <= rsfs_pkg::STEADY_TICKS_RST;
      cfg_r.erase_limit    <= rsfs_pkg::ERASE_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* design/rsfs_sched.sv */
// ----------------------------------------------------------------------------
// Record scheduler decision logic
// Holds the scheduling state and works out the result of one transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsfs_sched (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  rsfs_pkg::in_item_t   item,
  input  rsfs_pkg::cfg_regs_t  cfg,
  output rsfs_pkg::out_item_t  res
);

  logic [31:0]               seconds_r, seconds_nxt;
  logic [7:0]                steady_r, steady_nxt;
  logic                      fuel_r, fuel_nxt;
  logic [rsfs_pkg::SLOT_W-1:0] slots_r, slots_nxt;
  logic [15:0]               erase_r, erase_nxt;

  logic [32:0] sum;
  logic [31:0] sec_add;
  logic        due;
  logic [7:0]  steady_inc;
  logic        fire;
  logic        full;

  always_comb begin
    sum        = {1'b0, seconds_r} + {17'b0, item.elapsed_seconds};
    sec_add    = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    due        = ((sec_add > {15'b0, cfg.hour_limit}) && fuel_r) ||
                 (sec_add > {15'b0, cfg.day_limit});
    steady_inc = (steady_r == 8'hFF) ? steady_r : steady_r + 8'd1;
    fire       = steady_inc >= cfg.steady_ticks;
    full       = slots_r >= rsfs_pkg::SLOT_W'(rsfs_pkg::SLOT_COUNT);

    seconds_nxt = seconds_r;
    steady_nxt  = steady_r;
    fuel_nxt    = fuel_r;
    slots_nxt   = slots_r;
    erase_nxt   = erase_r;
    res         = '0;

    case (item.opcode)
      rsfs_pkg::OP_TICK: begin
        seconds_nxt = sec_add;
        if (due) begin
          if (item.battery_mv >= cfg.battery_min_mv) begin
            steady_nxt = steady_inc;
            if (fire) begin
              steady_nxt  = '0;
              fuel_nxt    = 1'b0;
              seconds_nxt = '0;
              if (erase_r > cfg.erase_limit) begin
                res.worn_out = 1'b1;
              end else begin
                if (full) begin
                  res.page_erased = 1'b1;
                  erase_nxt = (erase_r == 16'hFFFF) ? erase_r : erase_r + 16'd1;
                  slots_nxt = rsfs_pkg::SLOT_W'(1);
                end else begin
                  slots_nxt = slots_r + rsfs_pkg::SLOT_W'(1);
                end
                res.slot_number    = slots_nxt;
                res.record_written = 1'b1;
              end
            end
          end else begin
            steady_nxt = '0;
            fuel_nxt   = 1'b0;
          end
        end else begin
          fuel_nxt = 1'b0;
        end
      end
      rsfs_pkg::OP_FUEL: begin
        fuel_nxt = 1'b1;
      end
      rsfs_pkg::OP_QUERY: begin
        res.slot_number = slots_r;
      end
      default: begin
        fuel_nxt = fuel_r;
      end
    endcase

    res.wear_count = erase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seconds_r <= '0;
      steady_r  <= '0;
      fuel_r    <= 1'b0;
      slots_r   <= '0;
      erase_r   <= '0;
    end else if (step) begin
      seconds_r <= seconds_nxt;
      steady_r  <= steady_nxt;
      fuel_r    <= fuel_nxt;
      slots_r   <= slots_nxt;
      erase_r   <= erase_nxt;
    end
  end

endmodule

/* design/record_scheduler_flash_slots_core.sv */
// ----------------------------------------------------------------------------
// Record scheduler for a flash record ring
// Decides when a record is saved and which ring slot receives it.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle while its results are being
// taken. An accepted transaction lands in an input register; the decision
// logic then reads it together with the scheduling state, updates that state
// and loads the result register, from which the result is offered until it is
// taken. Both registers advance whenever the result register is empty or being
// taken, so input and output stalls are absorbed without gaps. Configuration
// writes are taken in every cycle and should only be issued while no
// transaction is in flight.
`timescale 1ns / 1ps

module record_scheduler_flash_slots_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  rsfs_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rsfs_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rsfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rsfs_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic                 in_valid_r;
  rsfs_pkg::in_item_t   in_data_r;
  logic                 out_valid_r;
  rsfs_pkg::out_item_t  out_data_r;
  logic                 advance;
  logic                 step;
  rsfs_pkg::cfg_regs_t  cfg;
  rsfs_pkg::out_item_t  res;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid_r || out_ready;
  assign step      = in_valid_r && advance;
  assign in_ready  = !in_valid_r || advance;

  rsfs_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  rsfs_sched u_sched (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (in_data_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (step) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* design/rsfs_checker.sv */
// ----------------------------------------------------------------------------
// Record scheduler port checker
// Watches the top-level ports for inconsistent result transactions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "record_scheduler_flash_slots_core_assert.svh"

module rsfs_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input rsfs_pkg::out_item_t             out_data
);

  `RSFS_ASSERT_NOW(a_erase_restarts_ring, clk, rst_n, out_valid && out_data.page_erased, out_data.record_written && (out_data.slot_number == rsfs_pkg::SLOT_W'(1)))

  `RSFS_ASSERT_NOW(a_written_has_slot, clk, rst_n, out_valid && out_data.record_written, (out_data.slot_number != '0) && !out_data.worn_out)

  `RSFS_ASSERT_NOW(a_slot_in_range, clk, rst_n, out_valid, out_data.slot_number <= rsfs_pkg::SLOT_W'(rsfs_pkg::SLOT_COUNT))

  `RSFS_ASSERT_NEXT(a_stalled_result_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind record_scheduler_flash_slots_core rsfs_checker u_rsfs_checker (.*);
